>>> src/spi_register_ppm_sum_generator_macros.svh
// assertion macros for the ppm sum generator checker
// no dependencies; included by the checker file only
`ifndef SPI_REGISTER_PPM_SUM_GENERATOR_MACROS_SVH
`define SPI_REGISTER_PPM_SUM_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppm sum generator check failed");

// next-cycle implication, disabled during reset
`define SPPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppm sum generator check failed");

`endif

>>> src/sppm_pkg.sv
// shared types and constants for the spi register ppm sum generator
// no dependencies
`default_nettype none

package sppm_pkg;

    typedef logic [6:0]  t_addr;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_us;
    typedef logic [19:0] t_ticks;
    typedef logic [3:0]  t_tpu;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SPI  = 1'b1;

    // spi word layout
    localparam int SPI_READ_BIT = 15;
    localparam int SPI_ADDR_HI  = 14;
    localparam int SPI_ADDR_LO  = 8;

    // config register indexes
    typedef enum logic [1:0] {
        CFG_TICKS_PER_US = 2'd0,
        CFG_PAUSE_US     = 2'd1,
        CFG_SYNC_US      = 2'd2
    } t_cfg_idx;

    // reset values
    localparam t_tpu RST_TICKS_PER_US = 4'd2;
    localparam t_us  RST_PAUSE_US     = 16'd500;
    localparam t_us  RST_SYNC_US      = 16'd4000;
    localparam t_us  NEUTRAL_US       = 16'd1500;
    localparam t_ticks MIN_SLOT_TICKS = 20'd1;

    // register file request, issued when an item is accepted
    typedef struct packed {
        logic  rd;
        logic  wr;
        t_addr addr;
        t_byte data;
    } t_reg_req;

endpackage

`default_nettype wire

>>> src/spi_register_ppm_sum_generator.sv
// spi register interface and ppm sum frame generator, top level
// depends on sppm_pkg and sppm_regfile
//
// usage:
//  - input channel (i_in_valid / o_in_stall): one request per item, either a
//    timer tick (i_command = 0) or a received 16-bit spi word (i_command = 1)
//  - output channel (o_out_valid / i_out_stall): one result per request with
//    the ppm line level, the reply byte and the frame busy flag
//  - config channel (i_cfg_valid / o_cfg_ready): always ready, writes ticks per
//    us, pause length and sync length; write only while the block is idle
//  - a request passes an input register that also issues the register file
//    access, then the frame state which is the result
//  - throughput is one request per cycle while the result is not stalled;
//    the frame update is one pass: a 16x4 slot length product, a pause product
//  - while the result is stalled the input register still takes one request,
//    then o_in_stall rises until the result is taken
//  - reset clears the register file to zero, sets channel widths to 1500 us,
//    the line high, no frame running and the config registers to defaults
`default_nettype none

module spi_register_ppm_sum_generator #(
    parameter int CHANNELS    = 8,
    parameter int REG_COUNT   = 128,
    parameter int TRIGGER_REG = 127
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input requests
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_command,
    input  wire  [15:0] i_spi_word,
    // results
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_ppm_level,
    output logic [7:0]  o_reply_byte,
    output logic        o_frame_busy,
    // config writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int SHADOW_BYTES = 2 * CHANNELS;
    localparam int SLOT_W       = $clog2(CHANNELS + 1);
    localparam int IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam sppm_pkg::t_addr TRIG_ADDR = sppm_pkg::t_addr'(TRIGGER_REG);
    localparam logic [SLOT_W:0] LAST_SLOT = (SLOT_W + 1)'(CHANNELS);

    // config registers
    sppm_pkg::t_tpu r_tpu;
    sppm_pkg::t_us  r_pause;
    sppm_pkg::t_us  r_sync;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu   <= sppm_pkg::RST_TICKS_PER_US;
            r_pause <= sppm_pkg::RST_PAUSE_US;
            r_sync  <= sppm_pkg::RST_SYNC_US;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (sppm_pkg::t_cfg_idx'(i_cfg_index))
                sppm_pkg::CFG_TICKS_PER_US: r_tpu   <= i_cfg_data[3:0];
                sppm_pkg::CFG_PAUSE_US:     r_pause <= i_cfg_data;
                sppm_pkg::CFG_SYNC_US:      r_sync  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_a_valid;
    logic r_o_valid;
    logic adv_en;
    logic in_accept;

    assign adv_en      = !(r_o_valid && i_out_stall);
    assign o_in_stall  = r_a_valid && !adv_en;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (adv_en) begin
                r_a_valid <= 1'b0;
            end
            if (adv_en) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // request decode at the input
    sppm_pkg::t_addr   in_addr;
    logic              in_spi;
    logic              in_read;
    logic              in_trig;
    sppm_pkg::t_reg_req reg_req;

    assign in_addr = i_spi_word[sppm_pkg::SPI_ADDR_HI:sppm_pkg::SPI_ADDR_LO];
    assign in_spi  = (i_command == sppm_pkg::CMD_SPI);
    assign in_read = in_spi && i_spi_word[sppm_pkg::SPI_READ_BIT];
    assign in_trig = in_spi && !in_read && (in_addr == TRIG_ADDR) && i_spi_word[0];

    always_comb begin
        reg_req.rd   = in_accept && in_read;
        reg_req.wr   = in_accept && in_spi && !in_read;
        reg_req.addr = in_addr;
        reg_req.data = {i_spi_word[7:1], i_spi_word[0] && !in_trig};
    end

    // input register
    logic r_a_tick;
    logic r_a_read;
    logic r_a_trig;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_tick <= (i_command == sppm_pkg::CMD_TICK);
            r_a_read <= in_read;
            r_a_trig <= in_trig;
        end
    end

    sppm_pkg::t_byte               rd_byte;
    logic [SHADOW_BYTES-1:0][7:0]  shadow;

    sppm_regfile #(
        .REG_COUNT    (REG_COUNT),
        .SHADOW_BYTES (SHADOW_BYTES)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (reg_req),
        .o_rd_byte (rd_byte),
        .o_shadow  (shadow)
    );

    // frame state, also the result register
    sppm_pkg::t_us       r_widths [CHANNELS];
    sppm_pkg::t_byte     r_reply;
    logic [SLOT_W-1:0]   r_slot;
    sppm_pkg::t_ticks    r_count;
    logic                r_level;
    logic                r_active;

    // slot length and pause length in ticks
    sppm_pkg::t_us     cur_us;
    sppm_pkg::t_ticks  slot_prod;
    sppm_pkg::t_ticks  slot_len;
    sppm_pkg::t_ticks  pause_len;
    sppm_pkg::t_ticks  count_inc;
    logic [SLOT_W:0]   slot_inc;
    logic              slot_done;

    assign cur_us    = (32'(r_slot) < CHANNELS) ? r_widths[r_slot[IDX_W-1:0]] : r_sync;
    assign slot_prod = sppm_pkg::t_ticks'(cur_us) * sppm_pkg::t_ticks'(r_tpu);
    assign slot_len  = (slot_prod == '0) ? sppm_pkg::MIN_SLOT_TICKS : slot_prod;
    assign pause_len = sppm_pkg::t_ticks'(r_pause) * sppm_pkg::t_ticks'(r_tpu);
    assign count_inc = r_count + 20'd1;
    assign slot_done = (count_inc >= slot_len);
    assign slot_inc  = {1'b0, r_slot} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_widths[ch] <= sppm_pkg::NEUTRAL_US;
            end
            r_reply  <= '0;
            r_slot   <= '0;
            r_count  <= '0;
            r_level  <= 1'b1;
            r_active <= 1'b0;
        end else if (r_a_valid && adv_en) begin
            if (r_a_read) begin
                r_reply <= rd_byte;
            end else if (r_a_trig) begin
                // latch widths and restart the frame
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    r_widths[ch] <= {shadow[2*ch+1], shadow[2*ch]};
                end
                r_slot   <= '0;
                r_count  <= '0;
                r_active <= 1'b1;
                r_level  <= 1'b0;
            end else if (r_a_tick && r_active) begin
                if (slot_done) begin
                    r_count <= '0;
                    if (slot_inc > LAST_SLOT) begin
                        r_slot   <= '0;
                        r_active <= 1'b0;
                        r_level  <= 1'b1;
                    end else begin
                        r_slot  <= slot_inc[SLOT_W-1:0];
                        r_level <= (pause_len == '0);
                    end
                end else begin
                    r_count <= count_inc;
                    r_level <= (count_inc >= pause_len);
                end
            end
        end
    end

    assign o_ppm_level  = r_level;
    assign o_reply_byte = r_reply;
    assign o_frame_busy = r_active;

endmodule

`default_nettype wire

>>> src/sppm_regfile.sv
// byte register file with zero-on-reset valid bits and a flop copy of the width bytes
// depends on sppm_pkg
`default_nettype none

module sppm_regfile #(
    parameter int REG_COUNT    = 128,
    parameter int SHADOW_BYTES = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire sppm_pkg::t_reg_req          i_req,
    output sppm_pkg::t_byte                  o_rd_byte,
    output logic [SHADOW_BYTES-1:0][7:0]     o_shadow
);

    localparam int MEM_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SH_W   = (SHADOW_BYTES > 1) ? $clog2(SHADOW_BYTES) : 1;

    sppm_pkg::t_byte r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [SHADOW_BYTES-1:0][7:0] r_shadow;
    sppm_pkg::t_byte r_rd_mem;
    logic r_rd_ok;

    logic              in_range;
    logic              in_shadow;
    logic [MEM_AW-1:0] mem_idx;
    logic [SH_W-1:0]   sh_idx;

    assign in_range  = (32'(i_req.addr) < REG_COUNT);
    assign in_shadow = (32'(i_req.addr) < SHADOW_BYTES);
    assign mem_idx   = i_req.addr[MEM_AW-1:0];
    assign sh_idx    = i_req.addr[SH_W-1:0];

    // storage array, one write or one read per request
    always_ff @(posedge i_clk) begin
        if (i_req.wr && in_range) begin
            r_mem[mem_idx] <= i_req.data;
        end
        if (i_req.rd) begin
            r_rd_mem <= r_mem[mem_idx];
        end
    end

    // valid bits, shadow bytes and read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_shadow <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_req.wr && in_range) begin
                r_valid[mem_idx] <= 1'b1;
            end
            if (i_req.wr && in_shadow) begin
                r_shadow[sh_idx] <= i_req.data;
            end
            if (i_req.rd) begin
                r_rd_ok <= in_range && r_valid[mem_idx];
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_byte = r_rd_ok ? r_rd_mem : '0;
    assign o_shadow  = r_shadow;

endmodule

`default_nettype wire

>>> src/sppm_checker.sv
// port-level checks for the ppm sum generator, bound to the top level
// depends on spi_register_ppm_sum_generator_macros.svh
`default_nettype none

`include "spi_register_ppm_sum_generator_macros.svh"

module sppm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire        o_ppm_level,
    input wire [7:0]  o_reply_byte,
    input wire        o_frame_busy
);

    // a stalled result holds
    `SPPM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable({o_ppm_level, o_reply_byte, o_frame_busy}))

    // no frame running means the line rests high
    `SPPM_ASSERT_NOW(a_idle_high, o_out_valid && !o_frame_busy, o_ppm_level)

    // input is only held off by a stalled result
    `SPPM_ASSERT_NOW(a_no_false_stall, !(o_out_valid && i_out_stall), !o_in_stall)

endmodule

bind spi_register_ppm_sum_generator sppm_checker u_sppm_checker (.*);

`default_nettype wire

>>> tb/spi_register_ppm_sum_generator_tb.sv
// self-checking testbench for the spi register ppm sum generator
// depends on sppm_pkg and the spi_register_ppm_sum_generator rtl; needs no other files
`default_nettype none

module spi_register_ppm_sum_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CHANNEL_COUNT = 8;
    localparam int              REG_FILE_SIZE = 128;
    localparam sppm_pkg::t_addr TRIGGER_ADDR  = 7'd127;
    localparam logic            SPI_READ      = 1'b1;
    localparam logic            SPI_WRITE     = 1'b0;
    localparam int              HOLD_CYCLES   = 40;
    localparam int              STUCK_LIMIT   = 2000;
    localparam int              SETTLE_CYCLES = 8;

    // one result: line level, reply byte, frame busy flag
    typedef struct packed {
        logic            level;
        sppm_pkg::t_byte reply;
        logic            busy;
    } t_line_state;

    // predicts the line state after every accepted request and checks results in order
    class ppm_frame_tracker;
        sppm_pkg::t_byte  regs [REG_FILE_SIZE];
        sppm_pkg::t_us    widths [CHANNEL_COUNT];
        sppm_pkg::t_byte  reply;
        logic [3:0]       slot;
        sppm_pkg::t_ticks count;
        logic             level;
        logic             busy;
        sppm_pkg::t_tpu   tpu;
        sppm_pkg::t_us    pause;
        sppm_pkg::t_us    sync;
        t_line_state      pending_states [$];
        int               mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (widths[i]) widths[i] = sppm_pkg::NEUTRAL_US;
            reply = '0;
            slot = '0;
            count = '0;
            level = 1'b1;
            busy = 1'b0;
            tpu = sppm_pkg::RST_TICKS_PER_US;
            pause = sppm_pkg::RST_PAUSE_US;
            sync = sppm_pkg::RST_SYNC_US;
            mismatches = 0;
        endfunction

        function void set_register(sppm_pkg::t_cfg_idx idx, logic [15:0] value);
            case (idx)
                sppm_pkg::CFG_TICKS_PER_US: tpu = value[3:0];
                sppm_pkg::CFG_PAUSE_US:     pause = value;
                sppm_pkg::CFG_SYNC_US:      sync = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_states.size();
        endfunction

        // ticks in the current slot, never less than one
        function sppm_pkg::t_ticks slot_length();
            sppm_pkg::t_us    us;
            sppm_pkg::t_ticks len;
            us = (slot < CHANNEL_COUNT) ? widths[slot] : sync;
            len = sppm_pkg::t_ticks'(us) * sppm_pkg::t_ticks'(tpu);
            return (len == '0) ? sppm_pkg::MIN_SLOT_TICKS : len;
        endfunction

        // trigger latches little-endian widths and restarts at slot 0, line low
        function void start_frame();
            for (int ch = 0; ch < CHANNEL_COUNT; ch++)
                widths[ch] = {regs[2*ch+1], regs[2*ch]};
            slot = '0;
            count = '0;
            busy = 1'b1;
            level = 1'b0;
        endfunction

        // one timer tick; nothing moves while no frame runs
        function void advance_tick();
            if (!busy)
                return;
            count = count + 1'b1;
            if (count >= slot_length()) begin
                count = '0;
                slot = slot + 1'b1;
                if (slot > CHANNEL_COUNT) begin
                    slot = '0;
                    busy = 1'b0;
                    level = 1'b1;
                    return;
                end
            end
            level = (count >= sppm_pkg::t_ticks'(pause) * sppm_pkg::t_ticks'(tpu));
        endfunction

        // apply one accepted request and queue the line state it leaves
        function void note_request(logic cmd, logic [15:0] word);
            sppm_pkg::t_addr a;
            sppm_pkg::t_byte d;
            a = word[sppm_pkg::SPI_ADDR_HI:sppm_pkg::SPI_ADDR_LO];
            d = word[7:0];
            if (cmd == sppm_pkg::CMD_SPI) begin
                if (word[sppm_pkg::SPI_READ_BIT] == SPI_READ) begin
                    reply = regs[a];
                end else if (a == TRIGGER_ADDR && d[0]) begin
                    regs[a] = {d[7:1], 1'b0};
                    start_frame();
                end else begin
                    regs[a] = d;
                end
            end else begin
                advance_tick();
            end
            pending_states.push_back('{level: level, reply: reply, busy: busy});
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // compare one accepted result with the oldest prediction
        task check_result(logic lvl, sppm_pkg::t_byte rep, logic bsy);
            t_line_state exp_state;
            if (pending_states.size() == 0) begin
                report("result with no request waiting");
                return;
            end
            exp_state = pending_states.pop_front();
            if (lvl !== exp_state.level)
                report($sformatf("ppm_level %b, predicted %b", lvl, exp_state.level));
            if (rep !== exp_state.reply)
                report($sformatf("reply_byte %h, predicted %h", rep, exp_state.reply));
            if (bsy !== exp_state.busy)
                report($sformatf("frame_busy %b, predicted %b", bsy, exp_state.busy));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        command = sppm_pkg::CMD_TICK;
    logic [15:0] spi_word = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = sppm_pkg::CFG_TICKS_PER_US;
    logic [15:0] cfg_data = '0;
    wire         in_stall;
    wire         out_valid;
    wire         ppm_level;
    wire  [7:0]  reply_byte;
    wire         frame_busy;
    wire         cfg_ready;

    ppm_frame_tracker tracker = new();
    int  requests_sent = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    spi_register_ppm_sum_generator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_command    (command),
        .i_spi_word   (spi_word),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_ppm_level  (ppm_level),
        .o_reply_byte (reply_byte),
        .o_frame_busy (frame_busy),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // result side stall: random short bursts, plus long holds on demand
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            out_stall <= 1'b1;
            stall_left <= HOLD_CYCLES;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            tracker.check_result(ppm_level, reply_byte, frame_busy);
    end

    // watchdog: ends the run after too long without any handshake
    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // offer one request, with an occasional idle gap before it
    task automatic send_request(logic cmd, logic [15:0] word);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        spi_word <= word;
        do @(posedge i_clk); while (in_stall);
        tracker.note_request(cmd, word);
        requests_sent++;
    endtask

    task automatic timer_tick();
        send_request(sppm_pkg::CMD_TICK, 16'($urandom));
    endtask

    task automatic write_reg(sppm_pkg::t_addr a, sppm_pkg::t_byte d);
        send_request(sppm_pkg::CMD_SPI, {SPI_WRITE, a, d});
    endtask

    task automatic read_reg(sppm_pkg::t_addr a);
        send_request(sppm_pkg::CMD_SPI, {SPI_READ, a, 8'($urandom)});
    endtask

    // stop offering until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // program all three registers; only called with nothing outstanding
    task automatic program_timing(sppm_pkg::t_tpu tpu, sppm_pkg::t_us pause,
                                  sppm_pkg::t_us sync);
        sppm_pkg::t_cfg_idx idx [3];
        logic [15:0]        val [3];
        idx = '{sppm_pkg::CFG_TICKS_PER_US, sppm_pkg::CFG_PAUSE_US, sppm_pkg::CFG_SYNC_US};
        val = '{16'(tpu), pause, sync};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge i_clk); while (!cfg_ready);
            tracker.set_register(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // random traffic, mostly width updates, a trigger and a run of ticks
    task automatic random_phase(int n_items, bit with_pressure);
        int              target;
        int              n;
        bit              held;
        bit              paused;
        sppm_pkg::t_addr a;
        target = requests_sent + n_items;
        held = 1'b0;
        paused = 1'b0;
        while (requests_sent < target) begin
            // long result hold right away, while requests keep coming
            if (with_pressure && !held) begin
                hold_asked++;
                held = 1'b1;
            end
            if (with_pressure && !paused && requests_sent > target - n_items / 3) begin
                drain();
                paused = 1'b1;
            end
            n = $urandom_range(0, 99);
            if (n < 75) begin
                // refresh a few width bytes, mostly small values
                repeat ($urandom_range(1, 4)) begin
                    a = 7'($urandom_range(0, 2 * CHANNEL_COUNT - 1));
                    if (a[0])
                        write_reg(a, ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'h00);
                    else
                        write_reg(a, 8'($urandom_range(0, 6)));
                end
                write_reg(TRIGGER_ADDR, 8'($urandom) | 8'h01);
                repeat ($urandom_range(20, 120)) begin
                    if (requests_sent < target) begin
                        n = $urandom_range(0, 11);
                        if (n == 0)
                            read_reg(7'($urandom));
                        else if (n == 1)
                            write_reg(7'($urandom_range(2 * CHANNEL_COUNT, 126)),
                                      8'($urandom));
                        else
                            timer_tick();
                    end
                end
            end else if (n < 90) begin
                repeat ($urandom_range(1, 6))
                    send_request(1'($urandom), 16'($urandom));
            end else begin
                write_reg(TRIGGER_ADDR, 8'($urandom) & 8'hFE);
                read_reg(TRIGGER_ADDR);
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: idle tick, reads, writes, trigger bit kept clear, zero widths
        timer_tick();
        read_reg(7'd0);
        write_reg(7'd126, 8'hFF);
        read_reg(7'd126);
        write_reg(TRIGGER_ADDR, 8'hFE);
        read_reg(TRIGGER_ADDR);
        write_reg(TRIGGER_ADDR, 8'h01);
        timer_tick();
        timer_tick();
        read_reg(TRIGGER_ADDR);
        drain();

        // shortest timing: zero width, width equal to pause, restart mid frame
        program_timing(4'd1, 16'd2, 16'd1);
        write_reg(7'd2, 8'd2);
        write_reg(7'd4, 8'd5);
        write_reg(TRIGGER_ADDR, 8'hFF);
        timer_tick();
        timer_tick();
        write_reg(TRIGGER_ADDR, 8'h03);
        repeat (16) timer_tick();
        drain();

        // zero ticks per microsecond: every slot lasts one tick
        program_timing(4'd0, 16'd3, 16'd4);
        write_reg(TRIGGER_ADDR, 8'h01);
        repeat (10) timer_tick();
        drain();

        // longest timing, frame cut short by the next phase's trigger
        program_timing(4'd15, 16'hFFFF, 16'hFFFF);
        write_reg(TRIGGER_ADDR, 8'h01);
        timer_tick();
        timer_tick();
        drain();

        for (int p = 0; p < 5; p++) begin
            if (p == 4)
                quiet = 1'b1;
            program_timing(4'($urandom_range(1, (p == 2) ? 4 : 2)),
                           16'($urandom_range(1, 6)), 16'($urandom_range(1, 10)));
            random_phase(70, p == 1);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
